@@ rtl/tcp_stream_reassembly_tracker_unit_assert.svh @@
// Assertion macros for the reassembly tracker
`ifndef TCP_STREAM_REASSEMBLY_TRACKER_UNIT_ASSERT_SVH
`define TCP_STREAM_REASSEMBLY_TRACKER_UNIT_ASSERT_SVH
// implication checked every clock, off during reset
`define TSR_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication
`define TSR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

@@ rtl/tsr_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tsr_pkg
// Shared types and constants of the TCP reassembly tracker.
// ----------------------------------------------------------------------------
package tsr_pkg;
	localparam int FRAG_SLOTS_DEF = 16;
	localparam int NUM_SOURCES = 2;

	localparam logic [2:0] KIND_WRITE = 3'd0;
	localparam logic [2:0] KIND_HELD = 3'd1;
	localparam logic [2:0] KIND_STALE = 3'd2;
	localparam logic [2:0] KIND_SRCS = 3'd3;
	localparam logic [2:0] KIND_FULL = 3'd4;
	localparam logic [2:0] KIND_CLEAR = 3'd5;

	// one beat as carried from front to back
	typedef struct packed {
		logic        mode;
		logic [31:0] seq_number;
		logic [15:0] seg_length;
		logic        syn_flag;
		logic [31:0] source_addr;
		logic [15:0] payload_handle;
	} seg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLASS,
		ST_SCAN,
		ST_EMIT,
		ST_DONE
	} state_t;
endpackage
`default_nettype wire

@@ rtl/tcp_stream_reassembly_tracker_unit.sv @@
// An input beat passes the front queue into the back end's current segment,
// which is classified before the first result is registered.
// The back end takes one item at a time; a write with held fragments adds scan
// passes over its source's held fragments, plus any output stall.
// Reset: arst_n empties the queue and clears output valid, stream slots, expected
// sequences and fragment counts; fragment contents are left as they are.
`default_nettype none
// ----------------------------------------------------------------------------
// tcp_stream_reassembly_tracker_unit
// Two-direction TCP segment reassembly tracker, front queue plus back end.
// ----------------------------------------------------------------------------
module tcp_stream_reassembly_tracker_unit #(
	parameter int FRAG_SLOTS = tsr_pkg::FRAG_SLOTS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        mode,
	input  wire logic [31:0] seq_number,
	input  wire logic [15:0] seg_length,
	input  wire logic        syn_flag,
	input  wire logic [31:0] source_addr,
	input  wire logic [15:0] payload_handle,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       kind,
	output logic [15:0]      out_handle,
	output logic [15:0]      skip_bytes,
	output logic [15:0]      write_length,
	output logic             last
);
	tsr_pkg::seg_t in_seg, q_seg;
	logic q_valid, q_ready;

	assign in_seg = '{mode: mode, seq_number: seq_number, seg_length: seg_length,
		syn_flag: syn_flag, source_addr: source_addr, payload_handle: payload_handle};

	tsr_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.in_seg(in_seg), .q_valid(q_valid), .q_ready(q_ready), .q_seg(q_seg)
	);

	tsr_back #(.FRAG_SLOTS(FRAG_SLOTS)) u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_ready(q_ready),
		.q_seg(q_seg), .out_valid(out_valid), .out_ready(out_ready), .kind(kind),
		.out_handle(out_handle), .skip_bytes(skip_bytes),
		.write_length(write_length), .last(last)
	);
endmodule
`default_nettype wire

@@ rtl/tsr_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tsr_front
// Input stage and two-entry queue feeding the back end.
// ----------------------------------------------------------------------------
module tsr_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire tsr_pkg::seg_t  in_seg,
	output logic                q_valid,
	input  wire logic           q_ready,
	output tsr_pkg::seg_t       q_seg
);
	tsr_pkg::seg_t mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign in_ready = (cnt_q != 2'd2);
	assign q_valid = (cnt_q != 2'd0);
	assign q_seg = mem_q[rp_q];
	assign push = in_valid && in_ready;
	assign pop = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= in_seg;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wp_q <= ~wp_q;
			if (pop)
				rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	`include "tcp_stream_reassembly_tracker_unit_assert.svh"
	`TSR_ASSERT_IMP(a_no_overflow, clk, arst_n, cnt_q == 2'd2, !push)
	`TSR_ASSERT_NEXT(a_cnt_push, clk, arst_n, push && !pop, cnt_q == $past(cnt_q) + 2'd1)
	`TSR_ASSERT_NEXT(a_cnt_pop, clk, arst_n, pop && !push, cnt_q == $past(cnt_q) - 2'd1)
endmodule
`default_nettype wire

@@ rtl/tsr_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tsr_back
// Stream state, fragment tables and result sequencing.
// ----------------------------------------------------------------------------
module tsr_back #(
	parameter int FRAG_SLOTS = tsr_pkg::FRAG_SLOTS_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          q_valid,
	output logic               q_ready,
	input  wire tsr_pkg::seg_t q_seg,
	output logic               out_valid,
	input  wire logic          out_ready,
	output logic [2:0]         kind,
	output logic [15:0]        out_handle,
	output logic [15:0]        skip_bytes,
	output logic [15:0]        write_length,
	output logic               last
);
	localparam int IW = (FRAG_SLOTS > 1) ? $clog2(FRAG_SLOTS) : 1;
	localparam int CW = $clog2(FRAG_SLOTS + 1);
	localparam int NS = tsr_pkg::NUM_SOURCES;

	tsr_pkg::state_t state_q, state_d;
	tsr_pkg::seg_t   cur_q;

	logic [31:0] slot_q [NS];
	logic [31:0] exp_q [NS];
	logic [CW-1:0] cnt_q [NS];
	// per-source shift tables, entry 0 newest
	logic [31:0] fseq_q [NS][FRAG_SLOTS];
	logic [15:0] flen_q [NS][FRAG_SLOTS];
	logic [15:0] fhdl_q [NS][FRAG_SLOTS];

	logic          src_q;
	logic [IW-1:0] idx_q;
	logic [CW-1:0] scan_q;
	logic          found_q;
	logic [IW-1:0] hit_q;

	logic          ov_q;
	logic [2:0]    kind_q;
	logic [15:0]   hdl_q, skp_q, wl_q;
	logic          last_q;

	// classification of current segment (one compare path)
	logic        m0, m1, e0, e1, hit, first;
	logic        sidx;
	logic [31:0] e, nseq, sq_t;
	logic [15:0] len_t, skp_t;
	logic [31:0] e_adv;

	always_comb begin
		m0 = (slot_q[0] == cur_q.source_addr);
		m1 = (slot_q[1] == cur_q.source_addr);
		e0 = (slot_q[0] == 32'd0);
		e1 = (slot_q[1] == 32'd0);
		hit = m0 || m1;
		first = !hit && (e0 || e1);
		sidx = hit ? m1 : !e0;
		e = exp_q[sidx];
		nseq = cur_q.seq_number + {16'd0, cur_q.seg_length};
		sq_t = cur_q.seq_number;
		len_t = cur_q.seg_length;
		skp_t = 16'd0;
		if (cur_q.seq_number < e && nseq > e) begin
			skp_t = 16'(e - cur_q.seq_number);
			len_t = 16'(nseq - e);
			sq_t = e;
		end
		e_adv = e + {16'd0, len_t} + {31'd0, cur_q.syn_flag};
	end

	logic scan_hit;
	logic wr_scan;
	logic ins_go, rm_go;
	assign scan_hit = (fseq_q[src_q][idx_q] == exp_q[src_q]);
	// in-order write with fragments held: its last flag waits for the scan
	assign wr_scan = !cur_q.mode && hit && (sq_t == e) && (cnt_q[sidx] != '0);
	assign ins_go = (state_q == tsr_pkg::ST_CLASS) && !cur_q.mode && hit && (sq_t > e)
		&& (cnt_q[sidx] < CW'(FRAG_SLOTS));
	assign rm_go = (state_q == tsr_pkg::ST_EMIT) && !ov_q && found_q;

	always_comb begin
		state_d = state_q;
		q_ready = 1'b0;
		unique case (state_q)
			tsr_pkg::ST_IDLE: begin
				q_ready = !ov_q;
				if (q_valid && !ov_q)
					state_d = tsr_pkg::ST_CLASS;
			end
			tsr_pkg::ST_CLASS: state_d = wr_scan ? tsr_pkg::ST_DONE : tsr_pkg::ST_EMIT;
			tsr_pkg::ST_SCAN: begin
				if (scan_hit || (scan_q + CW'(1) >= cnt_q[src_q]))
					state_d = tsr_pkg::ST_EMIT;
			end
			tsr_pkg::ST_EMIT: begin
				if (!ov_q) begin
					if (found_q)
						state_d = (cnt_q[src_q] == CW'(1)) ? tsr_pkg::ST_EMIT
							: tsr_pkg::ST_DONE;
					else
						state_d = tsr_pkg::ST_IDLE;
				end
			end
			tsr_pkg::ST_DONE: state_d = tsr_pkg::ST_SCAN;
			default: state_d = tsr_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= tsr_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	assign out_valid = ov_q;
	assign kind = kind_q;
	assign out_handle = hdl_q;
	assign skip_bytes = skp_q;
	assign write_length = wl_q;
	assign last = last_q;

	// output register and state updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
			last_q <= 1'b0;
			kind_q <= tsr_pkg::KIND_WRITE;
			hdl_q <= 16'd0;
			skp_q <= 16'd0;
			wl_q <= 16'd0;
			for (int s = 0; s < NS; s++) begin
				slot_q[s] <= 32'd0;
				exp_q[s] <= 32'd0;
				cnt_q[s] <= '0;
			end
			src_q <= 1'b0;
			idx_q <= '0;
			scan_q <= '0;
			found_q <= 1'b0;
			hit_q <= '0;
		end else begin
			unique case (state_q)
				tsr_pkg::ST_IDLE: ;
				tsr_pkg::ST_CLASS: begin
					src_q <= sidx;
					if (cur_q.mode) begin
						ov_q <= 1'b1;
						kind_q <= tsr_pkg::KIND_CLEAR;
						hdl_q <= 16'd0;
						skp_q <= 16'd0;
						wl_q <= 16'd0;
						last_q <= 1'b1;
						for (int s = 0; s < NS; s++) begin
							slot_q[s] <= 32'd0;
							exp_q[s] <= 32'd0;
							cnt_q[s] <= '0;
						end
					end else if (!hit && !first) begin
						ov_q <= 1'b1;
						kind_q <= tsr_pkg::KIND_SRCS;
						hdl_q <= cur_q.payload_handle;
						skp_q <= 16'd0;
						wl_q <= 16'd0;
						last_q <= 1'b1;
					end else if (first) begin
						slot_q[sidx] <= cur_q.source_addr;
						exp_q[sidx] <= nseq + {31'd0, cur_q.syn_flag};
						ov_q <= 1'b1;
						kind_q <= tsr_pkg::KIND_WRITE;
						hdl_q <= cur_q.payload_handle;
						skp_q <= 16'd0;
						wl_q <= cur_q.seg_length;
						last_q <= 1'b1;
					end else if (sq_t == e) begin
						// with fragments held the beat waits for the scan
						exp_q[sidx] <= e_adv;
						ov_q <= (cnt_q[sidx] == '0);
						kind_q <= tsr_pkg::KIND_WRITE;
						hdl_q <= cur_q.payload_handle;
						skp_q <= skp_t;
						wl_q <= len_t;
						last_q <= (cnt_q[sidx] == '0);
					end else if (sq_t > e) begin
						ov_q <= 1'b1;
						hdl_q <= cur_q.payload_handle;
						skp_q <= 16'd0;
						wl_q <= 16'd0;
						last_q <= 1'b1;
						if (cnt_q[sidx] >= CW'(FRAG_SLOTS)) begin
							kind_q <= tsr_pkg::KIND_FULL;
						end else begin
							cnt_q[sidx] <= cnt_q[sidx] + CW'(1);
							kind_q <= tsr_pkg::KIND_HELD;
						end
					end else begin
						ov_q <= 1'b1;
						kind_q <= tsr_pkg::KIND_STALE;
						hdl_q <= cur_q.payload_handle;
						skp_q <= 16'd0;
						wl_q <= 16'd0;
						last_q <= 1'b1;
					end
				end
				tsr_pkg::ST_DONE: begin
					idx_q <= '0;
					scan_q <= '0;
				end
				tsr_pkg::ST_SCAN: begin
					if (scan_hit) begin
						// another beat follows: send the waiting one, remember the hit
						ov_q <= 1'b1;
						found_q <= 1'b1;
						hit_q <= idx_q;
					end else if (scan_q + CW'(1) >= cnt_q[src_q]) begin
						// nothing fits: the waiting beat ends the item
						ov_q <= 1'b1;
						last_q <= 1'b1;
					end else begin
						idx_q <= idx_q + IW'(1);
						scan_q <= scan_q + CW'(1);
					end
				end
				tsr_pkg::ST_EMIT: begin
					if (ov_q) begin
						if (out_ready)
							ov_q <= 1'b0;
					end else if (found_q) begin
						// load the released fragment and unlink it
						found_q <= 1'b0;
						kind_q <= tsr_pkg::KIND_WRITE;
						hdl_q <= fhdl_q[src_q][hit_q];
						skp_q <= 16'd0;
						wl_q <= flen_q[src_q][hit_q];
						exp_q[src_q] <= exp_q[src_q] + {16'd0, flen_q[src_q][hit_q]};
						cnt_q[src_q] <= cnt_q[src_q] - CW'(1);
						ov_q <= (cnt_q[src_q] == CW'(1));
						last_q <= (cnt_q[src_q] == CW'(1));
					end
				end
				default: ;
			endcase
		end
	end

	// fragment tables: insert at the head, or close the gap of a released entry
	always_ff @(posedge clk) begin
		if (ins_go) begin
			for (int k = FRAG_SLOTS - 1; k > 0; k--) begin
				fseq_q[sidx][k] <= fseq_q[sidx][k-1];
				flen_q[sidx][k] <= flen_q[sidx][k-1];
				fhdl_q[sidx][k] <= fhdl_q[sidx][k-1];
			end
			fseq_q[sidx][0] <= sq_t;
			flen_q[sidx][0] <= len_t;
			fhdl_q[sidx][0] <= cur_q.payload_handle;
		end else if (rm_go) begin
			for (int k = 0; k < FRAG_SLOTS - 1; k++) begin
				if (k >= int'(hit_q)) begin
					fseq_q[src_q][k] <= fseq_q[src_q][k+1];
					flen_q[src_q][k] <= flen_q[src_q][k+1];
					fhdl_q[src_q][k] <= fhdl_q[src_q][k+1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == tsr_pkg::ST_IDLE && q_valid && !ov_q)
			cur_q <= q_seg;
	end

	`include "tcp_stream_reassembly_tracker_unit_assert.svh"
	`TSR_ASSERT_IMP(a_ready_idle, clk, arst_n, q_ready, state_q == tsr_pkg::ST_IDLE)
	`TSR_ASSERT_IMP(a_cnt_range, clk, arst_n, 1'b1, cnt_q[0] <= CW'(FRAG_SLOTS))
	`TSR_ASSERT_NEXT(a_hold_out, clk, arst_n, ov_q && !out_ready, ov_q && $stable(hdl_q))
endmodule
`default_nettype wire
